// ===== hdl/spdg_pkg.sv =====
package spdg_pkg;

    // Sizing
    localparam int MAX_V       = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int VIDX_W      = $clog2(MAX_V);
    localparam int VCNT_W      = $clog2(MAX_V + 1);
    localparam int MADDR_W     = 2 * VIDX_W;
    localparam int MEM_DEPTH   = 1 << MADDR_W;
    localparam int DIST_W      = 21;
    localparam int SUM_W       = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

    // Fixed field widths of the request and result items
    localparam int VFIELD_W = 5;
    localparam int EW_W     = 16;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd32;
    localparam logic [DIST_W-1:0] PATH_MAX  = '1;

    // Request command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    typedef struct packed {
        logic                command;
        logic [VFIELD_W-1:0] from_vertex;
        logic [VFIELD_W-1:0] to_vertex;
        logic [EW_W-1:0]     edge_weight;
    } t_in;

    typedef struct packed {
        logic [VFIELD_W-1:0] vertex_index;
        logic [DIST_W-1:0]   path_length;
        logic                unreachable;
        logic                last_result;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic               wr_edge;
        logic               run_init;
        logic               clr_wr;
        logic [MADDR_W-1:0] clr_addr;
        logic               pick_step;
        logic               mark;
        logic               rd_req;
        logic               emit;
        logic               last;
        logic [VIDX_W-1:0]  idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [VCNT_W-1:0] vcnt;
        logic              u_reached;
        logic              out_free;
    } t_sts;

endpackage

// ===== hdl/spdg_ctrl.sv =====
module spdg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_command,
    output logic            o_ready,
    output spdg_pkg::t_cmd  o_cmd,
    input  spdg_pkg::t_sts  i_sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_RELAX = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [spdg_pkg::VIDX_W-1:0]   r_idx, n_idx;
    logic [spdg_pkg::VCNT_W-1:0]   r_round, n_round;
    logic [spdg_pkg::MADDR_W-1:0]  r_clr, n_clr;

    logic accept;
    logic idx_last;
    logic round_last;

    assign o_ready    = (r_state == S_IDLE);
    assign accept     = i_valid & o_ready;
    assign idx_last   = ((spdg_pkg::VCNT_W'(r_idx) + spdg_pkg::VCNT_W'(1)) == i_sts.vcnt);
    assign round_last = ((r_round + spdg_pkg::VCNT_W'(2)) == i_sts.vcnt);

    // Sequencer: clear sweep, pick scan, mark, relax scan, drain, emit
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_round = r_round;
        n_clr   = r_clr;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        o_cmd.clr_addr = r_clr;
        o_cmd.last     = idx_last;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr = r_clr + spdg_pkg::MADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_command == spdg_pkg::CMD_ADD) begin
                        o_cmd.wr_edge = 1'b1;
                    end else begin
                        o_cmd.run_init = 1'b1;
                        n_idx   = '0;
                        n_round = '0;
                        if (i_sts.vcnt == spdg_pkg::VCNT_W'(1)) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_PICK;
                        end
                    end
                end
            end
            S_PICK: begin
                o_cmd.pick_step = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = S_MARK;
                end else begin
                    n_idx = r_idx + spdg_pkg::VIDX_W'(1);
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.u_reached) begin
                    n_state = S_RELAX;
                end else if (round_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_round = r_round + spdg_pkg::VCNT_W'(1);
                    n_state = S_PICK;
                end
            end
            S_RELAX: begin
                o_cmd.rd_req = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + spdg_pkg::VIDX_W'(1);
                end
            end
            S_DRAIN: begin
                // last relaxation lands this cycle
                if (round_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_round = r_round + spdg_pkg::VCNT_W'(1);
                    n_state = S_PICK;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (idx_last) begin
                        n_idx   = '0;
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_idx = r_idx + spdg_pkg::VIDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_round <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_round <= n_round;
            r_clr   <= n_clr;
        end
    end

`ifndef SYNTHESIS
    // final result of a run always hands over to the matrix clear
    a_last_to_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_CLEAR))
        else $error("run did not proceed to matrix clear");

    // never more than vertex_count-1 rounds
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> ((r_round + spdg_pkg::VCNT_W'(2)) <= i_sts.vcnt))
        else $error("round counter past last round");
`endif

endmodule

// ===== hdl/spdg_dpath.sv =====
module spdg_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spdg_pkg::t_in               i_data,
    input  logic                        i_cfg_we,
    input  logic [spdg_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  spdg_pkg::t_cmd              i_cmd,
    output spdg_pkg::t_sts              o_sts,
    output logic                        o_valid,
    input  logic                        i_ready,
    output spdg_pkg::t_out              o_data
);

    // Config
    logic [spdg_pkg::CFG_W-1:0]   r_vcount;
    logic [spdg_pkg::VCNT_W-1:0]  vcnt;

    // Weight matrix, upper triangle addressing {lo, hi}
    logic [spdg_pkg::WEIGHT_BITS-1:0] mem [spdg_pkg::MEM_DEPTH];
    logic [spdg_pkg::WEIGHT_BITS-1:0] r_rd_data;
    logic                             r_rd_valid;
    logic [spdg_pkg::VIDX_W-1:0]      r_rd_j;

    // Per-vertex state
    logic [spdg_pkg::DIST_W-1:0] r_dist [spdg_pkg::MAX_V];
    logic [spdg_pkg::MAX_V-1:0]  r_reached;
    logic [spdg_pkg::MAX_V-1:0]  r_visited;

    // Pick scan / current vertex
    logic                         r_have;
    logic [spdg_pkg::VIDX_W-1:0]  r_best;
    logic                         r_best_reached;
    logic [spdg_pkg::DIST_W-1:0]  r_best_dist;

    // Output stage
    logic           r_out_valid;
    spdg_pkg::t_out r_out;

    logic [spdg_pkg::VIDX_W-1:0]      e_from, e_to, e_lo, e_hi;
    logic [spdg_pkg::VIDX_W-1:0]      r_lo, r_hi;
    logic                             e_in_range;
    logic                             wr_en;
    logic [spdg_pkg::MADDR_W-1:0]     wr_addr;
    logic [spdg_pkg::WEIGHT_BITS-1:0] wr_data;
    logic [spdg_pkg::MADDR_W-1:0]     rd_addr;

    logic [spdg_pkg::VIDX_W-1:0]  ix;
    logic [spdg_pkg::DIST_W-1:0]  d_ix;
    logic                         rch_ix;
    logic                         vis_ix;
    logic [spdg_pkg::SUM_W-1:0]   sum;
    logic [spdg_pkg::DIST_W-1:0]  d_new;
    logic                         relax_en;
    logic                         have_eff;
    logic                         take;

    // Config register and clamped vertex count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= spdg_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_vcount == '0) begin
            vcnt = spdg_pkg::VCNT_W'(1);
        end else if (int'(r_vcount) > spdg_pkg::MAX_V) begin
            vcnt = spdg_pkg::VCNT_W'(spdg_pkg::MAX_V);
        end else begin
            vcnt = spdg_pkg::VCNT_W'(r_vcount);
        end
    end

    // Edge address: both directions share one entry
    assign e_from     = spdg_pkg::VIDX_W'(i_data.from_vertex);
    assign e_to       = spdg_pkg::VIDX_W'(i_data.to_vertex);
    assign e_in_range = (int'(i_data.from_vertex) < spdg_pkg::MAX_V) &&
                        (int'(i_data.to_vertex) < spdg_pkg::MAX_V);
    assign e_lo = (e_from < e_to) ? e_from : e_to;
    assign e_hi = (e_from < e_to) ? e_to : e_from;

    assign r_lo = (r_best < i_cmd.idx) ? r_best : i_cmd.idx;
    assign r_hi = (r_best < i_cmd.idx) ? i_cmd.idx : r_best;

    assign wr_en   = i_cmd.clr_wr | (i_cmd.wr_edge & e_in_range);
    assign wr_addr = i_cmd.clr_wr ? i_cmd.clr_addr : {e_lo, e_hi};
    assign wr_data = i_cmd.clr_wr ? '0 : spdg_pkg::WEIGHT_BITS'(i_data.edge_weight);
    assign rd_addr = {r_lo, r_hi};

    // Matrix memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_req) begin
            r_rd_data <= mem[rd_addr];
        end
        r_rd_j <= i_cmd.idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_req;
        end
    end

    // Single vertex-state read port
    assign ix     = r_rd_valid ? r_rd_j : i_cmd.idx;
    assign d_ix   = r_dist[ix];
    assign rch_ix = r_reached[ix];
    assign vis_ix = r_visited[ix];

    // Relaxation of neighbor r_rd_j through the current vertex
    assign sum   = spdg_pkg::SUM_W'(r_best_dist) + spdg_pkg::SUM_W'(r_rd_data);
    assign d_new = (sum > spdg_pkg::SUM_W'(spdg_pkg::PATH_MAX)) ?
                   spdg_pkg::PATH_MAX : spdg_pkg::DIST_W'(sum);
    assign relax_en = r_rd_valid && (r_rd_data != '0) && !vis_ix &&
                      (!rch_ix || (d_new < d_ix));

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_visited <= '0;
            r_reached <= spdg_pkg::MAX_V'(1);
            r_dist[0] <= '0;
        end else begin
            if (i_cmd.mark) begin
                r_visited[r_best] <= 1'b1;
            end
            if (relax_en) begin
                r_reached[r_rd_j] <= 1'b1;
                r_dist[r_rd_j]    <= d_new;
            end
        end
    end

    // Pick scan: least distance, unreached as infinite, lowest index on ties
    assign have_eff = r_have && (i_cmd.idx != '0);
    assign take = !vis_ix &&
                  (!have_eff || (rch_ix && (!r_best_reached || (d_ix < r_best_dist))));

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_step) begin
            if (!vis_ix) begin
                r_have <= 1'b1;
            end else if (i_cmd.idx == '0) begin
                r_have <= 1'b0;
            end
            if (take) begin
                r_best         <= i_cmd.idx;
                r_best_reached <= rch_ix;
                r_best_dist    <= d_ix;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.vertex_index <= spdg_pkg::VFIELD_W'(i_cmd.idx);
            r_out.path_length  <= rch_ix ? d_ix : '0;
            r_out.unreachable  <= !rch_ix;
            r_out.last_result  <= i_cmd.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign o_sts.vcnt      = vcnt;
    assign o_sts.u_reached = r_best_reached;
    assign o_sts.out_free  = !r_out_valid || i_ready;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_ready))
        else $error("result loaded over a pending result");

    a_init_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run_init |=> (r_reached[0] && (r_visited == '0)))
        else $error("run init did not seed the source");

    a_mark_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark |=> r_visited[$past(r_best)])
        else $error("selected vertex not marked visited");
`endif

endmodule

// ===== hdl/shortest_path_dense_graph_top.sv =====
// Single-source shortest paths from vertex 0 over an undirected weighted graph
// held in a 32x32 weight matrix (a weight of zero means no edge). An add-edge
// request (command 0) stores its weight for both directions; add-edge requests
// can follow back to back. A run request (command 1) over n = vertex_count
// vertices (0 counts as 1, above 32 as 32) makes n-1 selection rounds: each
// scans the per-vertex state, marks the selected vertex and, when that vertex
// is reachable, reads one matrix row through the single read port of the
// matrix memory. The n results then leave one per cycle in index order as the
// output side takes them, and a sweep then zeroes the matrix through its write
// port; the same sweep runs after reset. The input is held off until the sweep
// ends. vertex_count must be written only while the block is idle; the block
// itself does not enforce this.
module shortest_path_dense_graph_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  spdg_pkg::t_in               i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output spdg_pkg::t_out              o_data,
    input  logic                        i_cfg_we,
    input  logic [spdg_pkg::CFG_W-1:0]  i_cfg_wdata
);

    spdg_pkg::t_cmd cmd;
    spdg_pkg::t_sts sts;

    spdg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_data.command),
        .o_ready   (o_ready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    spdg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== sim/spdg_path_checker.sv =====
// Watches both channels and the vertex_count port, keeps its own copy of the
// graph and predicts the distance results of every run request.
module spdg_path_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  spdg_pkg::t_in              i_req,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  spdg_pkg::t_out             i_res,
    input  logic                       i_cfg_we,
    input  logic [spdg_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_result_count
);

    logic [spdg_pkg::EW_W-1:0]   weight_mat [spdg_pkg::MAX_V][spdg_pkg::MAX_V];
    logic [spdg_pkg::DIST_W-1:0] path_len [spdg_pkg::MAX_V];
    logic                        reached [spdg_pkg::MAX_V];
    logic                        settled [spdg_pkg::MAX_V];
    logic [spdg_pkg::CFG_W-1:0]  vertex_cfg = spdg_pkg::CFG_RESET;
    spdg_pkg::t_out              expected_paths [$];
    int                          mismatches = 0;
    int                          results_seen = 0;
    int                          queued = 0;

    assign o_fail_count   = mismatches;
    assign o_pending      = queued;
    assign o_result_count = results_seen;

    task automatic clear_weights();
        for (int r = 0; r < spdg_pkg::MAX_V; r++)
            for (int c = 0; c < spdg_pkg::MAX_V; c++)
                weight_mat[r][c] = '0;
    endtask

    // Dense Dijkstra from vertex 0, then queue one result per active vertex
    task automatic solve_paths();
        int                         n;
        int                         u;
        logic [spdg_pkg::SUM_W-1:0] sum;
        spdg_pkg::t_out             res;
        n = (vertex_cfg == 0) ? 1 :
            (vertex_cfg > spdg_pkg::MAX_V) ? spdg_pkg::MAX_V : int'(vertex_cfg);
        for (int i = 0; i < spdg_pkg::MAX_V; i++) begin
            path_len[i] = '0;
            reached[i]  = 1'b0;
            settled[i]  = 1'b0;
        end
        reached[0] = 1'b1;
        for (int r = 0; r + 1 < n; r++) begin
            // least distance among unsettled, unreached counts as infinite, low index wins ties
            u = -1;
            for (int i = 0; i < n; i++) begin
                if (!settled[i]) begin
                    if (u < 0)
                        u = i;
                    else if (reached[i] && (!reached[u] || path_len[i] < path_len[u]))
                        u = i;
                end
            end
            settled[u] = 1'b1;
            // an unreached vertex relaxes nothing
            if (reached[u]) begin
                for (int j = 0; j < n; j++) begin
                    if (weight_mat[u][j] != 0 && !settled[j]) begin
                        sum = path_len[u] + weight_mat[u][j];
                        if (sum > spdg_pkg::PATH_MAX)
                            sum = spdg_pkg::PATH_MAX;
                        if (!reached[j] || sum[spdg_pkg::DIST_W-1:0] < path_len[j]) begin
                            path_len[j] = sum[spdg_pkg::DIST_W-1:0];
                            reached[j]  = 1'b1;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            res.vertex_index = spdg_pkg::VFIELD_W'(i);
            res.path_length  = reached[i] ? path_len[i] : '0;
            res.unreachable  = !reached[i];
            res.last_result  = (i == n - 1);
            expected_paths.push_back(res);
        end
        clear_weights();
    endtask

    always @(posedge i_clk) begin
        spdg_pkg::t_out want;
        if (!i_rst_n) begin
            clear_weights();
            vertex_cfg = spdg_pkg::CFG_RESET;
            expected_paths.delete();
        end else begin
            if (i_cfg_we)
                vertex_cfg = i_cfg_wdata;

            // results: compare against the oldest expectation
            if (i_res_valid && i_res_ready) begin
                results_seen++;
                if (expected_paths.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: vertex %0d len %0d unreach %0b last %0b",
                             $time, i_res.vertex_index, i_res.path_length,
                             i_res.unreachable, i_res.last_result);
                end else begin
                    want = expected_paths.pop_front();
                    if (i_res.vertex_index !== want.vertex_index ||
                        i_res.path_length  !== want.path_length  ||
                        i_res.unreachable  !== want.unreachable  ||
                        i_res.last_result  !== want.last_result) begin
                        mismatches++;
                        $display("%0t: mismatch: expected vertex %0d len %0d unreach %0b last %0b",
                                 $time, want.vertex_index, want.path_length,
                                 want.unreachable, want.last_result);
                        $display("%0t:           actual   vertex %0d len %0d unreach %0b last %0b",
                                 $time, i_res.vertex_index, i_res.path_length,
                                 i_res.unreachable, i_res.last_result);
                    end
                end
            end

            // requests: edge loads go into the matrix both ways, runs predict
            if (i_req_valid && i_req_ready) begin
                if (i_req.command == spdg_pkg::CMD_ADD) begin
                    weight_mat[i_req.from_vertex][i_req.to_vertex] = i_req.edge_weight;
                    weight_mat[i_req.to_vertex][i_req.from_vertex] = i_req.edge_weight;
                end else begin
                    solve_paths();
                end
            end
        end
        queued = expected_paths.size();
    end

endmodule

// ===== sim/tb_shortest_path_dense_graph_top.sv =====
module tb_shortest_path_dense_graph_top;

    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 1100;   // covers the matrix clearing sweep
    localparam int RANDOM_ITEMS  = 100;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_GRAPH    = 2;
    localparam int LIMIT_CYCLES  = 600000;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       i_ready     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [spdg_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    spdg_pkg::t_in              i_data      = '0;
    logic                       o_ready;
    logic                       o_valid;
    spdg_pkg::t_out             o_data;

    int fail_count;
    int pending_paths;
    int result_count;
    int edge_loads = 0;
    int run_loads  = 0;
    int vcount_used = spdg_pkg::MAX_V;
    int hold_cnt;
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    shortest_path_dense_graph_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    spdg_path_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_req          (i_data),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_res          (o_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending_paths),
        .o_result_count (result_count)
    );

    function automatic spdg_pkg::t_in make_req(logic cmd, int from_v, int to_v, int w);
        spdg_pkg::t_in r;
        r.command     = cmd;
        r.from_vertex = spdg_pkg::VFIELD_W'(from_v);
        r.to_vertex   = spdg_pkg::VFIELD_W'(to_v);
        r.edge_weight = spdg_pkg::EW_W'(w);
        return r;
    endfunction

    function automatic void vertex_count_used(logic [spdg_pkg::CFG_W-1:0] value);
        vcount_used = (value == 0) ? 1 :
                      (value > spdg_pkg::MAX_V) ? spdg_pkg::MAX_V : int'(value);
    endfunction

    // Offer one request, with random gaps unless in a steady stretch
    task automatic send_req(input spdg_pkg::t_in req);
        while (!steady && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (req.command == spdg_pkg::CMD_RUN)
            run_loads++;
        else
            edge_loads++;
        @(negedge i_clk);
    endtask

    task automatic send_edge(int from_v, int to_v, int w);
        send_req(make_req(spdg_pkg::CMD_ADD, from_v, to_v, w));
    endtask

    task automatic send_run();
        send_req(make_req(spdg_pkg::CMD_RUN, $urandom_range(31), $urandom_range(31),
                          $urandom_range(65535)));
    endtask

    // Drain, let the clearing sweep finish, then write vertex_count
    task automatic set_vertex_count(input logic [spdg_pkg::CFG_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_paths != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        vertex_count_used(value);
    endtask

    // Result side: random back-pressure plus one long hold after a chosen run
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && o_valid) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(negedge i_clk);
            end
            i_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // Stimulus
    initial begin
        int graph_idx;
        int n_edges;
        int random_sent;
        int from_v;
        int to_v;
        int w;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, self-loop, island, improvement, removal, ties
        set_vertex_count(spdg_pkg::CFG_RESET);
        send_edge(0, 31, 65535);
        send_edge(31, 30, 65535);
        send_edge(0, 0, 5);
        send_edge(1, 2, 1);
        send_edge(0, 3, 10);
        send_edge(3, 4, 1);
        send_edge(0, 4, 20);
        send_edge(0, 5, 7);
        send_edge(5, 0, 0);
        send_edge(0, 6, 3);
        send_edge(0, 7, 3);
        send_edge(6, 8, 4);
        send_edge(7, 8, 4);
        send_run();
        // matrix was cleared by the run, so everything but vertex 0 is unreachable
        send_run();
        set_vertex_count(6'd1);
        send_edge(0, 1, 9);
        send_run();
        set_vertex_count(6'd0);
        send_run();
        set_vertex_count(6'd63);
        send_edge(0, 1, 1);
        send_edge(1, 31, 65535);
        send_run();
        // edges through a vertex above the count must be ignored by the run
        set_vertex_count(6'd5);
        send_edge(0, 20, 1);
        send_edge(20, 1, 1);
        send_edge(0, 1, 100);
        send_run();

        // random graphs, each a burst of edge loads closed by a run
        graph_idx   = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (graph_idx == 0 || (graph_idx != HOLD_GRAPH + 1 && $urandom_range(1) == 1)) begin
                case ($urandom_range(7))
                    0:       set_vertex_count(6'd0);
                    1:       set_vertex_count(6'd1);
                    2:       set_vertex_count(6'd2);
                    3:       set_vertex_count(6'd32);
                    4:       set_vertex_count(spdg_pkg::CFG_W'($urandom_range(33, 63)));
                    default: set_vertex_count(spdg_pkg::CFG_W'($urandom_range(3, 31)));
                endcase
            end
            steady  = (graph_idx == HOLD_GRAPH + 1 || graph_idx == HOLD_GRAPH + 2);
            n_edges = $urandom_range(4, 16);
            repeat (n_edges) begin
                from_v = ($urandom_range(99) < 85) ? $urandom_range(vcount_used - 1)
                                                   : $urandom_range(31);
                to_v   = ($urandom_range(99) < 85) ? $urandom_range(vcount_used - 1)
                                                   : $urandom_range(31);
                case ($urandom_range(9))
                    0:       w = 0;
                    1:       w = $urandom_range(65535);
                    2:       w = 65535 - $urandom_range(15);
                    default: w = $urandom_range(1, 20);
                endcase
                send_edge(from_v, to_v, w);
            end
            send_run();
            // hold the result side on this run while the next graph keeps offering
            if (graph_idx == HOLD_GRAPH)
                hold_req = 1'b1;
            random_sent += n_edges + 1;
            graph_idx++;
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (pending_paths != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Covered %0d edge loads and %0d runs over %0d random graphs;",
                 edge_loads, run_loads, graph_idx);
        $display("%0d distances checked, vertex counts 0 to 63, random stalls, one long hold.",
                 result_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("%0t: timeout with %0d results still expected", $time, pending_paths);
        $display("TEST FAILED");
        $finish;
    end

endmodule
